>>> hw/rtl/ilrc_pkg.sv
// Shared types, character codes and range-handling functions of the index list range counter.
// Used by ilrc_parse, ilrc_final and the top level; depends on nothing.
package ilrc_pkg;

  typedef enum logic [3:0] {
    PH_SKIP,
    PH_WS1,
    PH_SIGN1,
    PH_DIG1,
    PH_WS2,
    PH_WS2N,
    PH_SIGN2,
    PH_DIG2,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    FS_UNDEC,
    FS_OK,
    FS_NF,
    FS_INV
  } fstat_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  localparam int unsigned NumW = 31;
  localparam logic [NumW-1:0] INT_MAX = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    phase_e          phase;
    logic [NumW-1:0] first_num;
    logic [NumW-1:0] second_num;
    logic            neg;
    logic            big;
    logic [NumW-1:0] count;
    fstat_e          fstat;
  } parse_t;

  typedef struct packed {
    logic pending;
    logic out_free;
  } fin_ctrl_t;

  localparam parse_t PARSE_CLEAR = '{
    phase:      PH_SKIP,
    first_num:  '0,
    second_num: '0,
    neg:        1'b0,
    big:        1'b0,
    count:      '0,
    fstat:      FS_UNDEC
  };

  function automatic logic bad_number(parse_t s, logic [NumW-1:0] v);
    return s.big || (s.neg && (v != '0));
  endfunction

  // Close the first number at character c. A result phase of PH_SKIP means c is parsed again.
  function automatic parse_t end_first(parse_t s, logic [7:0] c, logic cm);
    parse_t r;
    r = s;
    if (bad_number(s, s.first_num)) begin
      r.fstat = FS_NF;
      r.phase = PH_DONE;
    end else if (!cm) begin
      r.fstat = ((c == CH_LF) || (c == CH_NUL)) ? FS_OK : FS_NF;
      r.phase = PH_DONE;
    end else if ((c == CH_NUL) || (c == CH_COMMA) || (c == CH_LF)) begin
      if (s.count == INT_MAX) begin
        r.fstat = FS_INV;
        r.phase = PH_DONE;
      end else begin
        r.count = s.count + 1'b1;
        r.phase = PH_SKIP;
      end
    end else if (c == CH_MINUS) begin
      r.second_num = '0;
      r.neg        = 1'b0;
      r.big        = 1'b0;
      r.phase      = PH_WS2;
    end else begin
      r.phase = PH_SKIP;
    end
    return r;
  endfunction

  // Close a range. A result phase of PH_SKIP means the ending character is parsed again.
  function automatic parse_t end_second(parse_t s);
    parse_t          r;
    logic [NumW-1:0] diff;
    logic [NumW:0]   sum;
    r    = s;
    diff = s.second_num - s.first_num;
    sum  = {1'b0, s.count} + {1'b0, diff};
    if (bad_number(s, s.second_num)) begin
      r.fstat = FS_INV;
      r.phase = PH_DONE;
    end else if (s.second_num > s.first_num) begin
      if (sum >= {1'b0, INT_MAX}) begin
        r.fstat = FS_INV;
        r.phase = PH_DONE;
      end else begin
        r.count = sum[NumW-1:0] + 1'b1;
        r.phase = PH_SKIP;
      end
    end else begin
      r.phase = PH_SKIP;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ilrc_parse.sv
// Character parser of the index list range counter: holds the parse state and advances it
// by one item per cycle while accept_i is high. Depends on ilrc_pkg.
module ilrc_parse import ilrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  input  logic       count_mode_i,
  output parse_t     state_o
);

  parse_t state_q, state_d;
  parse_t base, fed;
  logic   ended_q, ended_d;
  logic   str_end;
  parse_t e;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [NumW:0] accumulate(logic big, logic [NumW-1:0] v, logic [7:0] c);
    logic [NumW+3:0] t;
    logic [7:0]      d;
    d = c - CH_ZERO;
    t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{(NumW-4){1'b0}}, d};
    if (big) begin
      return {1'b1, v};
    end else if (t[NumW+3:NumW] != '0) begin
      return {1'b1, v};
    end else begin
      return {1'b0, t[NumW-1:0]};
    end
  endfunction

  // Handles a character in the separator skip phases and starts the first number.
  function automatic parse_t skip_ws(parse_t s, logic [7:0] c, logic ws1);
    parse_t r;
    r = s;
    if (!ws1 && ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA))) begin
      r.phase = PH_SKIP;
    end else if (is_ws(c)) begin
      r.phase = PH_WS1;
    end else begin
      r.first_num = '0;
      r.big       = 1'b0;
      r.neg       = 1'b0;
      if ((c == CH_PLUS) || (c == CH_MINUS)) begin
        r.neg   = (c == CH_MINUS);
        r.phase = PH_SIGN1;
      end else if (is_digit(c)) begin
        r.first_num = {{(NumW-8){1'b0}}, c - CH_ZERO};
        r.phase     = PH_DIG1;
      end else begin
        r.phase = PH_DONE;
      end
    end
    return r;
  endfunction

  assign str_end = (char_i == CH_NUL) || last_i;

  always_comb begin
    logic [NumW:0] acc;
    base = ended_q ? PARSE_CLEAR : state_q;
    fed  = base;
    e    = base;
    acc  = '0;
    unique case (base.phase) inside
      PH_SKIP: fed = skip_ws(base, char_i, 1'b0);
      PH_WS1:  fed = skip_ws(base, char_i, 1'b1);
      PH_SIGN1: begin
        if (is_digit(char_i)) begin
          acc           = accumulate(base.big, base.first_num, char_i);
          fed.big       = acc[NumW];
          fed.first_num = acc[NumW-1:0];
          fed.phase     = PH_DIG1;
        end else begin
          fed.phase = PH_DONE;
        end
      end
      PH_DIG1: begin
        if (is_digit(char_i)) begin
          acc           = accumulate(base.big, base.first_num, char_i);
          fed.big       = acc[NumW];
          fed.first_num = acc[NumW-1:0];
        end else begin
          e   = end_first(base, char_i, count_mode_i);
          fed = (e.phase == PH_SKIP) ? skip_ws(e, char_i, 1'b0) : e;
        end
      end
      PH_WS2, PH_WS2N: begin
        if (is_ws(char_i)) begin
          if ((char_i != CH_SPACE) && (char_i != CH_TAB)) begin
            fed.phase = PH_WS2N;
          end
        end else begin
          fed.second_num = '0;
          fed.big        = 1'b0;
          fed.neg        = 1'b0;
          if ((char_i == CH_PLUS) || (char_i == CH_MINUS)) begin
            fed.neg   = (char_i == CH_MINUS);
            fed.phase = PH_SIGN2;
          end else if (is_digit(char_i)) begin
            fed.second_num = {{(NumW-8){1'b0}}, char_i - CH_ZERO};
            fed.phase      = PH_DIG2;
          end else begin
            fed = skip_ws(fed, char_i, base.phase == PH_WS2N);
          end
        end
      end
      PH_SIGN2: begin
        if (is_digit(char_i)) begin
          acc            = accumulate(base.big, base.second_num, char_i);
          fed.big        = acc[NumW];
          fed.second_num = acc[NumW-1:0];
          fed.phase      = PH_DIG2;
        end else begin
          fed.phase = PH_DONE;
        end
      end
      PH_DIG2: begin
        if (is_digit(char_i)) begin
          acc            = accumulate(base.big, base.second_num, char_i);
          fed.big        = acc[NumW];
          fed.second_num = acc[NumW-1:0];
        end else begin
          e   = end_second(base);
          fed = (e.phase == PH_SKIP) ? skip_ws(e, char_i, 1'b0) : e;
        end
      end
      default: fed = base;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ended_d = ended_q;
    if (accept_i) begin
      state_d = (char_i == CH_NUL) ? base : fed;
      ended_d = str_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PARSE_CLEAR;
      ended_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ended_q <= ended_d;
    end
  end

  assign state_o = state_q;

endmodule

>>> hw/rtl/ilrc_final.sv
// String-end stage of the index list range counter: closes an open number, decides the
// status and holds the result register. Depends on ilrc_pkg.
module ilrc_final import ilrc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  parse_t          state_i,
  input  logic            count_mode_i,
  input  logic            out_ready_i,
  output fin_ctrl_t       ctrl_o,
  output logic            out_valid_o,
  output logic [NumW-1:0] value_o,
  output status_e         status_o
);

  logic            pending_q, pending_d;
  logic            out_valid_q, out_valid_d;
  logic [NumW-1:0] value_q, value_d;
  status_e         status_q, status_d;
  logic            out_free, commit;
  parse_t          s;

  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = pending_q && out_free;

  always_comb begin
    s = state_i;
    if (state_i.phase == PH_DIG1) begin
      s = end_first(state_i, CH_NUL, count_mode_i);
    end else if (state_i.phase == PH_DIG2) begin
      s = end_second(state_i);
    end
    value_d = '0;
    unique case (s.fstat)
      FS_UNDEC: begin
        if (count_mode_i && (s.count != '0)) begin
          status_d = ST_OK;
          value_d  = s.count;
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      FS_OK: begin
        status_d = ST_OK;
        value_d  = count_mode_i ? s.count : s.first_num;
      end
      FS_NF:   status_d = ST_NOTFOUND;
      default: status_d = ST_INVALID;
    endcase
  end

  always_comb begin
    pending_d   = pending_q;
    out_valid_d = out_valid_q;
    if (commit) begin
      pending_d = 1'b0;
    end
    if (start_i) begin
      pending_d = 1'b1;
    end
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign ctrl_o      = '{pending: pending_q, out_free: out_free};
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

>>> hw/rtl/index_list_range_counter.sv
// Index list range counter: takes list text such as "0-7,9,12-15" one byte per item and
// returns one count or value per string. Depends on ilrc_pkg, ilrc_parse and ilrc_final.
//
// One byte is accepted every cycle while s_axis_tready is high. The result of a string is
// registered in the parse state register, then the string-end stage and its result register,
// after the byte that ends it (a NUL byte, or any byte with tlast). s_axis_tready drops only
// while a finished string waits for the output register and that register is stalled. There
// is no clearing pass after reset.
module index_list_range_counter import ilrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [30:0] value, [32:31] status, [39:33] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i      // count_mode
);

  logic            count_mode_q;
  logic            accept, start;
  parse_t          state;
  fin_ctrl_t       fin_ctrl;
  logic [NumW-1:0] value;
  status_e         status;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !fin_ctrl.pending || fin_ctrl.out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = accept && ((s_axis_tdata == CH_NUL) || s_axis_tlast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_mode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_mode_q <= cfg_data_i;
    end
  end

  ilrc_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .count_mode_i (count_mode_q),
    .state_o      (state)
  );

  ilrc_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .state_i      (state),
    .count_mode_i (count_mode_q),
    .out_ready_i  (m_axis_tready),
    .ctrl_o       (fin_ctrl),
    .out_valid_o  (m_axis_tvalid),
    .value_o      (value),
    .status_o     (status)
  );

  assign m_axis_tdata = {7'b0, status, value};

  a_end_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> fin_ctrl.pending)
    else $error("string end did not queue a result");

  a_pending_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_ctrl.pending && !fin_ctrl.out_free) |=> fin_ctrl.pending)
    else $error("queued result dropped while output stalled");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_ctrl.pending && !fin_ctrl.out_free) |-> !s_axis_tready)
    else $error("item accepted over an unfinished string");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_ctrl.pending && fin_ctrl.out_free) |=> m_axis_tvalid)
    else $error("committed result not presented");

endmodule
